### src/tlpf_pkg.sv
`timescale 1ns / 1ps
package tlpf_pkg;

  localparam logic       ACT_ENQ = 1'b0;
  localparam logic       ACT_DEQ = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_INVALID  = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

endpackage

### src/tlpf_ctrl.sv
`timescale 1ns / 1ps
module tlpf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tlpf_pkg::stat_t stat,
  output tlpf_pkg::cmd_t  cmd
);

  tlpf_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlpf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.load_in  = 1'b0;
    cmd.exec     = 1'b0;
    cmd.load_out = 1'b0;
    case (state)
      tlpf_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = tlpf_pkg::S_EXEC;
        end
      end
      tlpf_pkg::S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = tlpf_pkg::S_OUT;
      end
      tlpf_pkg::S_OUT: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = tlpf_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tlpf_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### src/tlpf_dp.sv
`timescale 1ns / 1ps
module tlpf_dp #(
  parameter int QUEUE_DEPTH = 16,
  parameter int LEVELS      = 3
) (
  input  logic            clk,
  input  logic            rst,
  input  tlpf_pkg::cmd_t  cmd,
  output tlpf_pkg::stat_t stat,
  input  logic            action,
  input  logic [1:0]      priority_req,
  input  logic [7:0]      data_in,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      data_out,
  output logic [1:0]      status,
  output logic [1:0]      served_level
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int LW = $clog2(LEVELS);
  localparam int TOTAL = LEVELS * QUEUE_DEPTH;
  localparam int AW = $clog2(TOTAL);

  logic [7:0]    mem [TOTAL];
  logic [IW-1:0] head [LEVELS];
  logic [IW-1:0] tail [LEVELS];
  logic [CW-1:0] count [LEVELS];

  logic          act_r;
  logic [1:0]    prio_r;
  logic [7:0]    byte_r;

  logic [7:0]    rd_data;
  logic [1:0]    res_status;
  logic [1:0]    res_served;
  logic          res_from_mem;

  logic          lvl_ok;
  logic [LW-1:0] enq_q;
  logic          enq_full;
  logic          deq_found;
  logic [LW-1:0] deq_q;
  logic          do_enq;
  logic          do_deq;
  logic [IW-1:0] tail_sel;
  logic [IW-1:0] head_sel;
  logic [IW-1:0] tail_inc;
  logic [IW-1:0] head_inc;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  always_comb begin
    lvl_ok   = (prio_r != 2'd0) && (int'(prio_r) <= LEVELS);
    enq_q    = LW'(prio_r - 2'd1);
    enq_full = lvl_ok && (count[enq_q] == CW'(QUEUE_DEPTH));
    deq_found = 1'b0;
    deq_q     = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (count[i] != '0) begin
        deq_found = 1'b1;
        deq_q     = LW'(i);
      end
    end
    do_enq   = cmd.exec && (act_r == tlpf_pkg::ACT_ENQ) && lvl_ok && !enq_full;
    do_deq   = cmd.exec && (act_r == tlpf_pkg::ACT_DEQ) && deq_found;
    tail_sel = tail[enq_q];
    head_sel = head[deq_q];
    tail_inc = (tail_sel == IW'(QUEUE_DEPTH - 1)) ? '0 : tail_sel + 1'b1;
    head_inc = (head_sel == IW'(QUEUE_DEPTH - 1)) ? '0 : head_sel + 1'b1;
    wr_addr  = AW'(enq_q) * AW'(QUEUE_DEPTH) + AW'(tail_sel);
    rd_addr  = AW'(deq_q) * AW'(QUEUE_DEPTH) + AW'(head_sel);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r  <= action;
      prio_r <= priority_req;
      byte_r <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (do_enq) begin
      mem[wr_addr] <= byte_r;
    end
    if (cmd.exec) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
    end else begin
      if (do_enq) begin
        tail[enq_q]  <= tail_inc;
        count[enq_q] <= count[enq_q] + 1'b1;
      end
      if (do_deq) begin
        head[deq_q]  <= head_inc;
        count[deq_q] <= count[deq_q] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_from_mem <= 1'b0;
      res_served   <= 2'd0;
      if (act_r == tlpf_pkg::ACT_ENQ) begin
        if (!lvl_ok) begin
          res_status <= tlpf_pkg::ST_INVALID;
        end else if (enq_full) begin
          res_status <= tlpf_pkg::ST_OVERFLOW;
        end else begin
          res_status <= tlpf_pkg::ST_OK;
        end
      end else if (deq_found) begin
        res_status   <= tlpf_pkg::ST_OK;
        res_served   <= 2'({1'b0, deq_q} + 1'b1);
        res_from_mem <= 1'b1;
      end else begin
        res_status <= tlpf_pkg::ST_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      data_out     <= res_from_mem ? rd_data : 8'd0;
      status       <= res_status;
      served_level <= res_served;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.out_busy = out_valid && !out_ready;

endmodule

### src/three_level_priority_fifo_core.sv
`timescale 1ns / 1ps
// Path from input transfer to result valid: queue update with registered
// memory read, then output load (held while the output register stalls).
// Controller sequence: a new item is taken only after the last result is
// loaded, also while that result still waits on the output register.
// Reset (rst, synchronous): all queues empty, output register empty.
module three_level_priority_fifo_core #(
  parameter int QUEUE_DEPTH = 16,
  parameter int LEVELS      = 3
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // data_in
  input  logic [2:0] s_axis_tuser,   // action, priority_req[1:0]
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // data_out
  output logic [3:0] m_axis_tuser    // status[1:0], served_level[1:0]
);

  tlpf_pkg::cmd_t  cmd;
  tlpf_pkg::stat_t stat;
  logic [1:0]      status;
  logic [1:0]      served_level;

  tlpf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tlpf_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .LEVELS      (LEVELS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .action       (s_axis_tuser[0]),
    .priority_req (s_axis_tuser[2:1]),
    .data_in      (s_axis_tdata),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .data_out     (m_axis_tdata),
    .status       (status),
    .served_level (served_level)
  );

  assign m_axis_tuser = {served_level, status};

endmodule
